>>> design/pgmt_pkg.sv
// Shared types and codes for the paged guest memory translation block.
// No dependencies; imported by pgmt_frame_mem and paged_guest_memory_translate.
`timescale 1ns / 1ps
`default_nettype none

package pgmt_pkg;

  localparam int PAGE_SHIFT_DEF           = 12;
  localparam int VIRT_PAGE_INDEX_BITS_DEF = 10;
  localparam int FRAME_COUNT_DEF          = 256;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_MAP   = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [2:0] KIND_WRITE_BASE = 3'd3;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FAULT = 2'd1,
    STATUS_NOMAP = 2'd2
  } status_e;

  typedef struct packed {
    logic en;
    logic we;
  } fm_req_t;

endpackage

`default_nettype wire

>>> design/pgmt_frame_mem.sv
// Byte-wide guest frame memory, one port, registered read data.
// Depends on pgmt_pkg for the port request struct.
`timescale 1ns / 1ps
`default_nettype none

module pgmt_frame_mem
  import pgmt_pkg::*;
#(
  parameter int DEPTH  = 1048576,
  parameter int ADDR_W = 20
) (
  input  wire logic              clk_i,
  input  wire fm_req_t           req_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [7:0]        wdata_i,
  output logic      [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/paged_guest_memory_translate.sv
// Top level: single-level page table MMU over byte-wide guest frame memory.
// Depends on pgmt_pkg and pgmt_frame_mem.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------------------
//  command   | start / busy            | mode_i, access_size_i, address_i, write_data_i
//  result    | done_o (1-cycle strobe) | read_data_o, status_o, fault_seen_o,
//            |                         | fault_address_o, fault_kind_o
//
// After reset both memories are zeroed, one entry a cycle, over the addresses 0 to
// max(2**VIRT_PAGE_INDEX_BITS, FRAME_COUNT << PAGE_SHIFT) - 1 (1048576 addresses by default).
// A map, a fault or an unused mode keeps busy high in ST_LOOKUP only; a read or write of
// n bytes adds ST_MEM, one byte a cycle via the single frame memory port, and ST_FIN.
// done_o is high in the first cycle with busy low; the next item can be taken in that cycle.
// The receiver cannot stall: each result is presented exactly once.
`timescale 1ns / 1ps
`default_nettype none

module paged_guest_memory_translate
  import pgmt_pkg::*;
#(
  parameter int PAGE_SHIFT           = PAGE_SHIFT_DEF,
  parameter int VIRT_PAGE_INDEX_BITS = VIRT_PAGE_INDEX_BITS_DEF,
  parameter int FRAME_COUNT          = FRAME_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode_i,
  input  wire logic [1:0]  access_size_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] write_data_i,
  output logic             done_o,
  output logic [31:0]      read_data_o,
  output logic [1:0]       status_o,
  output logic             fault_seen_o,
  output logic [31:0]      fault_address_o,
  output logic [2:0]       fault_kind_o
);

  localparam int PT_DEPTH    = 1 << VIRT_PAGE_INDEX_BITS;
  localparam int FRAME_IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int NFF_W       = $clog2(FRAME_COUNT + 1);
  localparam int PTE_W       = FRAME_IDX_W + 1;
  localparam int PA_W        = FRAME_IDX_W + PAGE_SHIFT;
  localparam int MEM_BYTES   = FRAME_COUNT << PAGE_SHIFT;
  localparam int CLR_W       = (PA_W > VIRT_PAGE_INDEX_BITS) ? PA_W : VIRT_PAGE_INDEX_BITS;
  localparam int CLR_DEPTH   = (PT_DEPTH > MEM_BYTES) ? PT_DEPTH : MEM_BYTES;
  localparam int CLR_LAST    = CLR_DEPTH - 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_MEM,
    ST_FIN
  } state_e;

  state_e                    state_q;
  logic [CLR_W-1:0]          clr_q;
  logic [1:0]                mode_q;
  logic [1:0]                size_q;
  logic [31:0]               addr_q;
  logic [31:0]               wdata_q;
  logic [NFF_W-1:0]          nff_q;
  logic [PA_W-1:0]           pa_q;
  logic [1:0]                idx_q;
  logic [1:0]                last_q;
  logic [1:0]                lane_q;
  logic                      cap_q;
  logic [31:0]               racc_q;
  logic                      done_q;
  logic [31:0]               read_data_q;
  status_e                   status_q;
  logic                      fault_q;
  logic [31:0]               fault_addr_q;
  logic [2:0]                fault_kind_q;

  logic [PTE_W-1:0]          pt_q [PT_DEPTH];
  logic [PTE_W-1:0]          pt_rd_q;
  logic                      pt_en;
  logic                      pt_we;
  logic [VIRT_PAGE_INDEX_BITS-1:0] pt_addr;
  logic [PTE_W-1:0]          pt_wdata;

  fm_req_t                   fm_req;
  logic [PA_W-1:0]           fm_addr;
  logic [7:0]                fm_wdata;
  logic [7:0]                fm_rdata;

  logic [31:0]               vpn_in;
  logic [31:0]               vpn_q;
  logic                      vpn_ok;
  logic                      nff_full;
  logic                      clr_pt;
  logic                      clr_mem;
  logic [PA_W-1:0]           pa_nxt;
  logic [PA_W-1:0]           pa_first;
  logic [31:0]               rdata_fin;
  logic [1:0]                size_in;

  assign vpn_in   = address_i >> PAGE_SHIFT;
  assign vpn_q    = addr_q >> PAGE_SHIFT;
  assign vpn_ok   = (vpn_q >> VIRT_PAGE_INDEX_BITS) == 32'd0;
  assign nff_full = nff_q == NFF_W'(FRAME_COUNT);
  assign clr_pt   = {1'b0, clr_q} < (CLR_W + 1)'(PT_DEPTH);
  assign clr_mem  = {1'b0, clr_q} < (CLR_W + 1)'(MEM_BYTES);
  assign pa_nxt   = ({1'b0, pa_q} + (PA_W + 1)'(1) == (PA_W + 1)'(MEM_BYTES)) ?
                    '0 : pa_q + PA_W'(1);
  assign pa_first = {pt_rd_q[FRAME_IDX_W-1:0], addr_q[PAGE_SHIFT-1:0]};
  assign size_in  = (access_size_i > SIZE_WORD) ? SIZE_WORD : access_size_i;

  always_comb begin
    rdata_fin = racc_q;
    if (cap_q) begin
      rdata_fin[{lane_q, 3'b000} +: 8] = fm_rdata;
    end
  end

  // page table port
  always_comb begin
    pt_en    = 1'b0;
    pt_we    = 1'b0;
    pt_addr  = vpn_q[VIRT_PAGE_INDEX_BITS-1:0];
    pt_wdata = {1'b1, nff_q[FRAME_IDX_W-1:0]};
    case (state_q)
      ST_CLEAR: begin
        pt_en    = clr_pt;
        pt_we    = 1'b1;
        pt_addr  = clr_q[VIRT_PAGE_INDEX_BITS-1:0];
        pt_wdata = '0;
      end
      ST_IDLE: begin
        pt_en   = start;
        pt_addr = vpn_in[VIRT_PAGE_INDEX_BITS-1:0];
      end
      ST_LOOKUP: begin
        pt_en = (mode_q == MODE_MAP) && vpn_ok && !nff_full;
        pt_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pt_en) begin
      if (pt_we) begin
        pt_q[pt_addr] <= pt_wdata;
      end else begin
        pt_rd_q <= pt_q[pt_addr];
      end
    end
  end

  // frame memory port
  always_comb begin
    fm_req   = '0;
    fm_addr  = pa_q;
    fm_wdata = wdata_q[{idx_q, 3'b000} +: 8];
    case (state_q)
      ST_CLEAR: begin
        fm_req.en = clr_mem;
        fm_req.we = 1'b1;
        fm_addr   = clr_q[PA_W-1:0];
        fm_wdata  = '0;
      end
      ST_MEM: begin
        fm_req.en = 1'b1;
        fm_req.we = mode_q == MODE_WRITE;
      end
      default: ;
    endcase
  end

  pgmt_frame_mem #(
    .DEPTH  (MEM_BYTES),
    .ADDR_W (PA_W)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .req_i   (fm_req),
    .addr_i  (fm_addr),
    .wdata_i (fm_wdata),
    .rdata_o (fm_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      mode_q       <= MODE_READ;
      size_q       <= SIZE_BYTE;
      addr_q       <= '0;
      wdata_q      <= '0;
      nff_q        <= '0;
      pa_q         <= '0;
      idx_q        <= '0;
      last_q       <= '0;
      lane_q       <= '0;
      cap_q        <= 1'b0;
      racc_q       <= '0;
      done_q       <= 1'b0;
      read_data_q  <= '0;
      status_q     <= STATUS_OK;
      fault_q      <= 1'b0;
      fault_addr_q <= '0;
      fault_kind_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + CLR_W'(1);
          if (clr_q == CLR_W'(CLR_LAST)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            mode_q  <= mode_i;
            size_q  <= size_in;
            addr_q  <= address_i;
            wdata_q <= write_data_i;
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          read_data_q <= '0;
          status_q    <= STATUS_OK;
          idx_q       <= '0;
          cap_q       <= 1'b0;
          racc_q      <= '0;
          state_q     <= ST_IDLE;
          done_q      <= 1'b1;
          if (mode_q == MODE_MAP) begin
            if (!vpn_ok || nff_full) begin
              status_q <= STATUS_NOMAP;
            end else begin
              nff_q <= nff_q + NFF_W'(1);
            end
          end else if (mode_q == MODE_READ || mode_q == MODE_WRITE) begin
            if (!vpn_ok || !pt_rd_q[PTE_W-1]) begin
              status_q     <= STATUS_FAULT;
              fault_q      <= 1'b1;
              fault_addr_q <= addr_q;
              fault_kind_q <= 3'(size_q) +
                              ((mode_q == MODE_WRITE) ? KIND_WRITE_BASE : 3'd0);
            end else begin
              pa_q    <= pa_first;
              last_q  <= (size_q == SIZE_BYTE) ? 2'd0 :
                         (size_q == SIZE_HALF) ? 2'd1 : 2'd3;
              done_q  <= 1'b0;
              state_q <= ST_MEM;
            end
          end
        end
        ST_MEM: begin
          if (cap_q) begin
            racc_q[{lane_q, 3'b000} +: 8] <= fm_rdata;
          end
          lane_q <= idx_q;
          cap_q  <= mode_q == MODE_READ;
          pa_q   <= pa_nxt;
          idx_q  <= idx_q + 2'd1;
          if (idx_q == last_q) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          read_data_q <= rdata_fin;
          status_q    <= STATUS_OK;
          done_q      <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy            = state_q != ST_IDLE;
  assign done_o          = done_q;
  assign read_data_o     = read_data_q;
  assign status_o        = status_q;
  assign fault_seen_o    = fault_q;
  assign fault_address_o = fault_addr_q;
  assign fault_kind_o    = fault_kind_q;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_LOOKUP || state_q == ST_FIN))
    else $error("result strobe without a finishing step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == STATUS_FAULT) |-> fault_q)
    else $error("fault result without sticky fault flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nff_q <= NFF_W'(FRAME_COUNT))
    else $error("free frame counter past frame count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != STATUS_OK) |-> (read_data_q == 32'd0))
    else $error("nonzero read data on error result");
`endif

endmodule

`default_nettype wire
